FILE: design/assert_macros.svh
// Assertion macros used by the port checker of the packer block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at each rising clock edge, disabled while reset is low.
`define ASSERT_CLK_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("packer assertion failed");

// Property checked at each rising clock edge, reset included.
`define ASSERT_CLK(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("packer assertion failed after reset");

`endif

FILE: design/nsp_pkg.sv
// Package for the nine-bit SPI packer: request and result types.
// No dependencies.
`timescale 1ns / 1ps

package nsp_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_data;
        logic       last_item;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       dc_level;
        logic       last_out;
    } t_out_item;

    typedef struct packed {
        logic      two;
        t_out_item first;
        t_out_item second;
    } t_pack_res;

    localparam logic [2:0] LAST_COUNT = 3'd7;

endpackage

FILE: design/nsp_packer.sv
// Packing logic: mode register, pending bits and the one-pass byte forming.
// Depends on nsp_pkg.
`timescale 1ns / 1ps

module nsp_packer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic               i_load,
    input  nsp_pkg::t_in_item  i_item,
    output nsp_pkg::t_pack_res o_res
);
    import nsp_pkg::*;

    logic        r_mode;
    logic [2:0]  r_count;
    logic [2:0]  n_count;
    logic [6:0]  r_left;
    logic [6:0]  n_left;
    logic [8:0]  word;
    logic [15:0] combined;
    logic [3:0]  remain;
    logic [7:0]  byte0;
    logic [6:0]  keep;
    logic [7:0]  flush;

    always_comb begin
        word     = {i_item.is_data, i_item.data_byte};
        combined = {r_left, word};
        remain   = {1'b0, r_count} + 4'd1;
        byte0    = 8'(combined >> remain);
        keep     = combined[6:0] & 7'((8'd1 << remain[2:0]) - 8'd1);
        flush    = 8'({1'b0, keep} << (4'd8 - remain));

        o_res.two    = 1'b0;
        o_res.first  = '{out_byte: byte0, dc_level: 1'b0, last_out: 1'b1};
        o_res.second = '{out_byte: flush, dc_level: 1'b0, last_out: 1'b1};
        n_count      = 3'd0;
        n_left       = 7'd0;

        if (!r_mode) begin
            o_res.first = '{out_byte: i_item.data_byte, dc_level: i_item.is_data,
                            last_out: 1'b1};
        end else if (r_count == LAST_COUNT) begin
            o_res.two             = 1'b1;
            o_res.first.last_out  = 1'b0;
            o_res.second.out_byte = combined[7:0];
        end else if (i_item.last_item) begin
            o_res.two            = 1'b1;
            o_res.first.last_out = 1'b0;
        end else begin
            n_count = remain[2:0];
            n_left  = keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b1;
            r_count <= 3'd0;
            r_left  <= 7'd0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (i_load) begin
                r_count <= n_count;
                r_left  <= n_left;
            end
        end
    end

endmodule

FILE: design/nsp_out_buf.sv
// Result buffer: holds the one or two bytes of a packed request and
// presents them in order on the output channel. Depends on nsp_pkg.
`timescale 1ns / 1ps

module nsp_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  nsp_pkg::t_pack_res i_res,
    output logic               o_can_load,
    output logic               o_valid,
    input  logic               i_ready,
    output nsp_pkg::t_out_item o_item
);
    import nsp_pkg::*;

    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_out_item  r_res0;
    t_out_item  r_res1;
    logic       pop;

    assign pop        = (r_cnt != 2'd0) && i_ready;
    assign o_can_load = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && pop);
    assign o_valid    = (r_cnt != 2'd0);
    assign o_item     = r_res0;

    always_comb begin
        n_cnt = r_cnt;
        if (i_load) begin
            n_cnt = i_res.two ? 2'd2 : 2'd1;
        end else if (pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res0 <= i_res.first;
            r_res1 <= i_res.second;
        end else if (pop) begin
            r_res0 <= r_res1;
        end
    end

endmodule

FILE: design/nine_bit_spi_packer_top.sv
// Top level of the nine-bit SPI packer: input register, packer, result buffer.
// Depends on nsp_pkg, nsp_packer and nsp_out_buf.
`timescale 1ns / 1ps

// Usage:
// Requests enter on i_in_valid / o_in_ready with i_in_item (byte, data tag,
// last flag). Results leave on o_out_valid / i_out_ready with o_out_item.
// The mode register is written with i_cfg_we / i_cfg_wdata while idle; it
// resets to three-wire mode. In four-wire mode each request gives one byte
// with its data/command level. In three-wire mode each request gives one or
// two bytes: two when a full byte of pending bits builds up or when a last
// request flushes pending bits padded with zeros.
// Path: an accepted request is held in the input register, then its result
// bytes are loaded into the result buffer when it can take them.
// Throughput: while the receiver is ready, one request per cycle when each
// gives one byte, and the result buffer delivers one byte per cycle; after a
// two-byte request, loads wait until its first byte is taken. On a receiver
// stall, results hold and the input register fills, then o_in_ready drops.
// Reset (synchronous, active low) empties both stages, clears the pending
// bits and selects three-wire mode.
module nine_bit_spi_packer_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  nsp_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output nsp_pkg::t_out_item o_out_item
);
    import nsp_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      can_load;
    logic      advance;
    t_pack_res pack_res;

    assign advance    = r_in_valid && can_load;
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    nsp_packer u_packer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_load      (advance),
        .i_item      (r_in_item),
        .o_res       (pack_res)
    );

    nsp_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance),
        .i_res      (pack_res),
        .o_can_load (can_load),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_item     (o_out_item)
    );

endmodule

FILE: design/nsp_checker.sv
// Port-level checker for the nine-bit SPI packer, bound to the top level.
// Depends on nsp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nsp_port_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input nsp_pkg::t_out_item o_out_item
);
    import nsp_pkg::*;

    `ASSERT_CLK_RST(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
    `ASSERT_CLK_RST(a_dc_single, i_clk, i_rst_n, o_out_valid && o_out_item.dc_level |-> o_out_item.last_out)
    `ASSERT_CLK_RST(a_second_follows, i_clk, i_rst_n, o_out_valid && i_out_ready && !o_out_item.last_out |=> o_out_valid)
    `ASSERT_CLK(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid)

endmodule

bind nine_bit_spi_packer_top nsp_port_checker u_nsp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

FILE: verif/nsp_checker.sv
// Checker for the nine-bit SPI packer: watches the mode port, the request channel and the result channel,
// predicts the packed byte stream and compares every result byte with it.
// Depends on nsp_pkg for the request and result types.
`timescale 1ns / 1ps

module nsp_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  nsp_pkg::t_in_item  i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  nsp_pkg::t_out_item i_out_item,
    output int                 o_fail_count,
    output int                 o_outstanding,
    output int                 o_result_count
);

    localparam int REPORT_LIMIT = 10;

    logic                three_wire = 1'b1;
    logic [7:0]          pend_bits  = 8'h00;
    logic [2:0]          pend_cnt   = 3'd0;
    nsp_pkg::t_out_item  expected_bytes[$];
    int                  fail_count   = 0;
    int                  result_count = 0;
    int                  queued       = 0;

    assign o_fail_count   = fail_count;
    assign o_outstanding  = queued;
    assign o_result_count = result_count;

    task automatic predict_packed_bytes(input nsp_pkg::t_in_item req);
        nsp_pkg::t_out_item made[2];
        int                 n;
        logic [7:0]         held;
        logic [15:0]        joined;
        logic [15:0]        shifted;
        logic [3:0]         rest;
        logic [7:0]         flush;
        n = 0;
        if (!three_wire) begin
            pend_bits = 8'h00;
            pend_cnt  = 3'd0;
            made[0].out_byte = req.data_byte;
            made[0].dc_level = req.is_data;
            made[0].last_out = 1'b1;
            expected_bytes.push_back(made[0]);
            return;
        end
        held    = pend_bits & ((8'd1 << pend_cnt) - 8'd1);
        joined  = {held[6:0], req.is_data, req.data_byte};
        rest    = {1'b0, pend_cnt} + 4'd1;
        shifted = joined >> rest;
        made[0].out_byte = shifted[7:0];
        made[0].dc_level = 1'b0;
        made[0].last_out = 1'b0;
        n = 1;
        if (rest == 4'd8) begin
            made[1].out_byte = joined[7:0];
            made[1].dc_level = 1'b0;
            made[1].last_out = 1'b0;
            n = 2;
            pend_bits = 8'h00;
            pend_cnt  = 3'd0;
        end else begin
            pend_bits = joined[7:0] & ((8'd1 << rest) - 8'd1);
            pend_cnt  = rest[2:0];
        end
        if (req.last_item && pend_cnt != 3'd0) begin
            flush = pend_bits << (4'd8 - {1'b0, pend_cnt});
            made[n].out_byte = flush;
            made[n].dc_level = 1'b0;
            made[n].last_out = 1'b0;
            n = n + 1;
            pend_bits = 8'h00;
            pend_cnt  = 3'd0;
        end
        made[n - 1].last_out = 1'b1;
        for (int k = 0; k < n; k++) begin
            expected_bytes.push_back(made[k]);
        end
    endtask

    task automatic compare_byte(input nsp_pkg::t_out_item got);
        nsp_pkg::t_out_item want;
        result_count++;
        if (expected_bytes.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
                $display("Result %0d arrived with nothing expected: byte=%02h dc=%0b last=%0b",
                         result_count, got.out_byte, got.dc_level, got.last_out);
            end
        end else begin
            want = expected_bytes.pop_front();
            if (got.out_byte !== want.out_byte || got.dc_level !== want.dc_level ||
                got.last_out !== want.last_out) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT) begin
                    $display("Result %0d mismatch: expected byte=%02h dc=%0b last=%0b, got byte=%02h dc=%0b last=%0b",
                             result_count, want.out_byte, want.dc_level, want.last_out,
                             got.out_byte, got.dc_level, got.last_out);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            three_wire = 1'b1;
            pend_bits  = 8'h00;
            pend_cnt   = 3'd0;
            expected_bytes.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                compare_byte(i_out_item);
            end
            if (i_in_valid && i_in_ready) begin
                predict_packed_bytes(i_in_item);
            end
            if (i_cfg_we) begin
                three_wire = i_cfg_wdata;
            end
        end
        queued = expected_bytes.size();
    end

endmodule

FILE: verif/tb_nine_bit_spi_packer_top.sv
// Testbench top for the nine-bit SPI packer: clock, reset, mode writes and request stimulus.
// Depends on nsp_pkg, nine_bit_spi_packer_top and nsp_checker, which checks the result stream.
`timescale 1ns / 1ps

module tb_nine_bit_spi_packer_top;

    import nsp_pkg::*;

    localparam int   CLK_HALF     = 4;
    localparam int   RESET_CYCLES = 10;
    localparam int   LIMIT_CYCLES = 200000;
    localparam int   LONG_HOLD    = 200;
    localparam int   DRAIN_TAIL   = 8;
    localparam int   SEG_COUNT    = 8;
    localparam int   SEG_ITEMS    = 50;
    localparam int   MAX_GAP      = 6;
    localparam logic MODE_FOUR_WIRE  = 1'b0;
    localparam logic MODE_THREE_WIRE = 1'b1;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    logic       cfg_wdata = 1'b0;
    logic       in_valid  = 1'b0;
    logic       out_ready = 1'b0;
    t_in_item   in_item   = '0;
    logic       in_ready;
    logic       out_valid;
    t_out_item  out_item;

    int fail_count;
    int outstanding;
    int result_count;
    int cycles      = 0;
    int sent        = 0;
    int mode_writes = 0;
    int rx_gap      = 0;
    bit rx_hold_req = 1'b0;
    bit no_idle     = 1'b0;

    nine_bit_spi_packer_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    nsp_checker u_pack_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_in_item      (in_item),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_out_item     (out_item),
        .o_fail_count   (fail_count),
        .o_outstanding  (outstanding),
        .o_result_count (result_count)
    );

    always begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("tb_nine_bit_spi_packer_top: FAIL");
            $finish;
        end
    end

    // The receiver waits a drawn number of cycles before each result, or one long stretch.
    initial begin
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            if (rx_hold_req) begin
                rx_gap      = LONG_HOLD;
                rx_hold_req = 1'b0;
            end
            if (rx_gap > 0) begin
                out_ready <= 1'b0;
                rx_gap = rx_gap - 1;
            end else begin
                out_ready <= 1'b1;
            end
            @(posedge clk);
            if (out_valid && out_ready) begin
                rx_gap = no_idle ? 0 : $urandom_range(MAX_GAP, 0);
            end
            @(negedge clk);
        end
    end

    function automatic t_in_item make_req(input logic [7:0] data_byte, input logic is_data,
                                          input logic last_item);
        t_in_item req;
        req.data_byte = data_byte;
        req.is_data   = is_data;
        req.last_item = last_item;
        return req;
    endfunction

    task automatic send_req(input t_in_item req);
        int gap;
        gap = no_idle ? 0 : $urandom_range(MAX_GAP, 0);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (DRAIN_TAIL) @(negedge clk);
    endtask

    task automatic write_mode(input logic three_wire);
        cfg_we    <= 1'b1;
        cfg_wdata <= three_wire;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        mode_writes++;
    endtask

    initial begin
        int   len;
        int   left;
        logic last;
        logic mode;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Walk the pending count from zero to seven; the next request, though flagged
        // last, then gives two bytes with no flush.
        send_req(make_req(8'h00, 1'b0, 1'b0));
        send_req(make_req(8'hFF, 1'b1, 1'b0));
        send_req(make_req(8'hA5, 1'b1, 1'b0));
        send_req(make_req(8'h5A, 1'b0, 1'b0));
        send_req(make_req(8'h80, 1'b1, 1'b0));
        send_req(make_req(8'h01, 1'b0, 1'b0));
        send_req(make_req(8'hFF, 1'b0, 1'b0));
        send_req(make_req(8'h00, 1'b1, 1'b1));
        send_req(make_req(8'hFF, 1'b1, 1'b1));
        send_req(make_req(8'h00, 1'b0, 1'b1));
        // Leave bits pending so that the switch to four-wire mode must discard them.
        send_req(make_req(8'h7F, 1'b1, 1'b0));
        send_req(make_req(8'hC3, 1'b0, 1'b0));
        send_req(make_req(8'h3C, 1'b1, 1'b0));
        drain_results();
        write_mode(MODE_FOUR_WIRE);
        send_req(make_req(8'h00, 1'b0, 1'b0));
        send_req(make_req(8'hFF, 1'b1, 1'b1));
        send_req(make_req(8'h81, 1'b1, 1'b0));
        send_req(make_req(8'h7E, 1'b0, 1'b1));
        drain_results();
        write_mode(MODE_THREE_WIRE);
        send_req(make_req(8'h96, 1'b1, 1'b1));
        drain_results();

        for (int seg = 0; seg < SEG_COUNT; seg++) begin
            if (seg == 0) begin
                mode = MODE_THREE_WIRE;
            end else if (seg == 1) begin
                mode = MODE_FOUR_WIRE;
            end else begin
                mode = ($urandom_range(3, 0) != 0) ? MODE_THREE_WIRE : MODE_FOUR_WIRE;
            end
            write_mode(mode);
            no_idle = (seg == 2);
            if (seg == 3) begin
                rx_hold_req = 1'b1;
            end
            left = SEG_ITEMS;
            while (left > 0) begin
                len = $urandom_range(12, 1);
                for (int k = 0; k < len && left > 0; k++) begin
                    last = (k == len - 1);
                    if ($urandom_range(7, 0) == 0) begin
                        last = 1'($urandom_range(1, 0));
                    end
                    send_req(make_req(8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)),
                                      last));
                    left--;
                end
            end
            drain_results();
        end
        no_idle = 1'b0;

        $display("Run covered %0d requests and %0d result bytes over %0d mode writes,",
                 sent, result_count, mode_writes);
        $display("with both wiring modes, open transfers across mode changes and a long output stall.");
        if (fail_count == 0) begin
            $display("tb_nine_bit_spi_packer_top: PASS");
        end else begin
            $display("tb_nine_bit_spi_packer_top: FAIL");
        end
        $finish;
    end

endmodule
